FILE: rtl/core/gnos_pkg.sv
package gnos_pkg;

   localparam int DEFAULT_MAP_SIDE   = 256;
   localparam int DEFAULT_MAX_RADIUS = 31;

   localparam int CELL_W     = 8;
   localparam int COORD_W    = 16;
   localparam int DIM_W      = 9;
   localparam int RAD_W      = 5;
   localparam int OFS_W      = RAD_W + 1;
   localparam int DIST_W     = 11;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [DIM_W-1:0]         RESET_MAP_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]         RESET_MAP_HEIGHT = 9'd256;
   localparam logic [RAD_W-1:0]         RESET_RADIUS     = 5'd10;
   localparam logic signed [CELL_W-1:0] RESET_THRESHOLD  = 8'sd100;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 8'd3;

   typedef struct packed {
      logic                    valid;
      logic                    in_map;
      logic                    last;
      logic signed [OFS_W-1:0] dx;
      logic signed [OFS_W-1:0] dy;
   } scan_tag_type;

endpackage

FILE: rtl/core/gnos_ram.sv
module gnos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gnos_scan_seq.sv
module gnos_scan_seq import gnos_pkg::*; #(
   parameter int MAP_SIDE = DEFAULT_MAP_SIDE,
   localparam int AddrW = $clog2(MAP_SIDE * MAP_SIDE)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] start_x,
   input  logic [DIM_W-1:0] start_y,
   input  logic [RAD_W-1:0] radius,
   input  logic [DIM_W-1:0] eff_width,
   input  logic [DIM_W-1:0] eff_height,
   output logic [AddrW-1:0] rd_addr,
   output scan_tag_type     tag
);

   localparam int NbW = DIM_W + 2;

   logic                    active_ff, active_in;
   logic [RAD_W-1:0]        r_ff, r_in;
   logic signed [OFS_W-1:0] dx_ff, dx_in;
   logic signed [OFS_W-1:0] dy_ff, dy_in;
   logic [DIM_W-1:0]        cx_ff, cx_in;
   logic [DIM_W-1:0]        cy_ff, cy_in;
   scan_tag_type            tag_ff, tag_in;

   logic signed [OFS_W-1:0] r_pos;
   logic signed [OFS_W-1:0] start_neg;
   logic                    row_end;
   logic                    last;
   logic signed [NbW-1:0]   nx;
   logic signed [NbW-1:0]   ny;
   logic                    in_map;

   always_comb begin
      r_pos     = $signed({1'b0, r_ff});
      start_neg = -$signed({1'b0, radius});
      row_end   = (dx_ff == r_pos);
      last      = row_end && (dy_ff == r_pos);
      nx        = $signed({2'b00, cx_ff}) + NbW'(dx_ff);
      ny        = $signed({2'b00, cy_ff}) + NbW'(dy_ff);
      in_map    = !nx[NbW-1] && !ny[NbW-1] &&
                  (nx[DIM_W:0] < {1'b0, eff_width}) &&
                  (ny[DIM_W:0] < {1'b0, eff_height});
      rd_addr   = AddrW'(ny[DIM_W:0]) * AddrW'(MAP_SIDE) + AddrW'(nx[DIM_W:0]);

      active_in = active_ff;
      r_in      = r_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      if (start) begin
         active_in = 1'b1;
         r_in      = radius;
         dx_in     = start_neg;
         dy_in     = start_neg;
         cx_in     = start_x;
         cy_in     = start_y;
      end else if (active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else if (row_end) begin
            dx_in = -r_pos;
            dy_in = dy_ff + OFS_W'(1);
         end else begin
            dx_in = dx_ff + OFS_W'(1);
         end
      end

      tag_in.valid  = active_ff;
      tag_in.in_map = in_map;
      tag_in.last   = last;
      tag_in.dx     = dx_ff;
      tag_in.dy     = dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tag_ff.valid <= 1'b0;
      end else begin
         active_ff    <= active_in;
         tag_ff.valid <= tag_in.valid;
      end
      r_ff          <= r_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      tag_ff.in_map <= tag_in.in_map;
      tag_ff.last   <= tag_in.last;
      tag_ff.dx     <= tag_in.dx;
      tag_ff.dy     <= tag_in.dy;
   end

   assign tag = tag_ff;

endmodule

FILE: rtl/core/gnos_dist_unit.sv
module gnos_dist_unit import gnos_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  scan_tag_type             tag,
   input  logic signed [CELL_W-1:0] rd_cost,
   input  logic signed [CELL_W-1:0] threshold,
   output logic                     done,
   output logic                     found,
   output logic [DIST_W-1:0]        best
);

   logic              done_ff, done_in;
   logic              found_ff, found_in;
   logic [DIST_W-1:0] best_ff, best_in;

   logic signed [2*OFS_W-1:0] dx_sq;
   logic signed [2*OFS_W-1:0] dy_sq;
   logic [DIST_W-1:0]         dist_sq;
   logic                      hit;

   always_comb begin
      dx_sq   = tag.dx * tag.dx;
      dy_sq   = tag.dy * tag.dy;
      dist_sq = DIST_W'(unsigned'(dx_sq)) + DIST_W'(unsigned'(dy_sq));
      hit     = tag.valid && tag.in_map && (rd_cost >= threshold);

      done_in  = tag.valid && tag.last;
      found_in = found_ff;
      best_in  = best_ff;
      if (clear) begin
         found_in = 1'b0;
         best_in  = '0;
      end else if (hit && (!found_ff || dist_sq < best_ff)) begin
         found_in = 1'b1;
         best_in  = dist_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         found_ff <= found_in;
      end
      best_ff <= best_in;
   end

   assign done  = done_ff;
   assign found = found_ff;
   assign best  = best_ff;

endmodule

FILE: rtl/core/grid_nearest_obstacle_search_unit.sv
// A cell write is accepted whenever the unit is not busy with a query.
// A query inside the map scans the (2R+1)^2 cells around it, R being the radius register
// capped at MAX_RADIUS, one cell per cycle through the grid memory's single read port;
// rsp_tvalid rises when the result is loaded; req_tready returns high in that same cycle.
// A query outside the map skips the scan and is answered through the pending flag.
// Synchronous reset restores the register defaults; the grid memory is not cleared.
module grid_nearest_obstacle_search_unit import gnos_pkg::*; #(
   parameter int MAP_SIDE   = DEFAULT_MAP_SIDE,
   parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cell_x [15:0], cell_y [31:16], cell_cost [39:32]
   input  logic [39:0]           req_tdata,
   // func [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // min_dist_sq [10:0], zero fill [15:11]
   output logic [15:0]           rsp_tdata,
   // found [0]
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AddrW   = $clog2(MAP_SIDE * MAP_SIDE);
   localparam int SideClip = (MAP_SIDE > 511) ? 511 : MAP_SIDE;
   localparam int RadClip  = (MAX_RADIUS > 31) ? 31 : MAX_RADIUS;

   logic [DIM_W-1:0]         map_width_ff, map_width_in;
   logic [DIM_W-1:0]         map_height_ff, map_height_in;
   logic [RAD_W-1:0]         radius_ff, radius_in;
   logic signed [CELL_W-1:0] threshold_ff, threshold_in;
   logic                     busy_ff, busy_in;
   logic                     pending_ff, pending_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;

   logic signed [COORD_W-1:0] req_x;
   logic signed [COORD_W-1:0] req_y;
   logic signed [CELL_W-1:0]  req_cost;
   logic [DIM_W-1:0]          eff_width;
   logic [DIM_W-1:0]          eff_height;
   logic [RAD_W-1:0]          eff_radius;
   logic                      accept;
   logic                      req_in_map;
   logic                      wr_en;
   logic [AddrW-1:0]          wr_addr;
   logic                      query;
   logic                      load;
   logic [AddrW-1:0]          rd_addr;
   logic signed [CELL_W-1:0]  rd_data;
   scan_tag_type              tag;
   logic                      scan_done;
   logic                      scan_found;
   logic [DIST_W-1:0]         scan_best;

   always_comb begin
      req_x    = req_tdata[15:0];
      req_y    = req_tdata[31:16];
      req_cost = req_tdata[39:32];

      eff_width  = (map_width_ff > DIM_W'(SideClip)) ? DIM_W'(SideClip) : map_width_ff;
      eff_height = (map_height_ff > DIM_W'(SideClip)) ? DIM_W'(SideClip) : map_height_ff;
      eff_radius = (radius_ff > RAD_W'(RadClip)) ? RAD_W'(RadClip) : radius_ff;

      req_tready = !busy_ff;
      accept     = req_tvalid && req_tready;
      req_in_map = !req_x[COORD_W-1] && !req_y[COORD_W-1] &&
                   (req_x < $signed({7'b0, eff_width})) &&
                   (req_y < $signed({7'b0, eff_height}));
      query      = accept && (req_tuser == FUNC_QUERY);
      wr_en      = accept && (req_tuser == FUNC_WRITE) && req_in_map;
      wr_addr    = AddrW'(req_y[DIM_W-1:0]) * AddrW'(MAP_SIDE) +
                   AddrW'(req_x[DIM_W-1:0]);

      load = pending_ff && (!rsp_valid_ff || rsp_tready);

      busy_in    = busy_ff;
      pending_in = pending_ff;
      if (query) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
      if ((query && !req_in_map) || scan_done) begin
         pending_in = 1'b1;
      end else if (load) begin
         pending_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_dist_in  = rsp_dist_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = scan_found;
         rsp_dist_in  = scan_best;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      radius_in     = radius_ff;
      threshold_in  = threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_wdata[DIM_W-1:0];
            CSR_MAP_HEIGHT: map_height_in = csr_wdata[DIM_W-1:0];
            CSR_RADIUS:     radius_in     = csr_wdata[RAD_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_wdata[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= RESET_MAP_WIDTH;
         map_height_ff <= RESET_MAP_HEIGHT;
         radius_ff     <= RESET_RADIUS;
         threshold_ff  <= RESET_THRESHOLD;
         busy_ff       <= 1'b0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         radius_ff     <= radius_in;
         threshold_ff  <= threshold_in;
         busy_ff       <= busy_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   gnos_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAP_SIDE * MAP_SIDE)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cost),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gnos_scan_seq #(
      .MAP_SIDE (MAP_SIDE)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (query && req_in_map),
      .start_x    (req_x[DIM_W-1:0]),
      .start_y    (req_y[DIM_W-1:0]),
      .radius     (eff_radius),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .rd_addr    (rd_addr),
      .tag        (tag)
   );

   gnos_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .clear     (query),
      .tag       (tag),
      .rd_cost   (rd_data),
      .threshold (threshold_ff),
      .done      (scan_done),
      .found     (scan_found),
      .best      (scan_best)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {5'b0, rsp_dist_ff};

endmodule
